/* hdl/crbm_pkg.sv */
package crbm_pkg;

    localparam int PAGE_MAX_BITS = 8;
    localparam int OFS_BITS      = 13;
    localparam int ROM_BITS      = 21;

    localparam logic [15:0] SCC_SWITCH_ADDR = 16'h9000;
    localparam logic [7:0]  SCC_KEY         = 8'h3F;
    localparam logic [7:0]  SCC_REG_PAGE    = 8'h98;

    localparam logic CFG_MAPPER_TYPE = 1'b0;
    localparam logic CFG_BANK_MASK   = 1'b1;

    typedef enum logic [2:0] {
        MAP_GEN8K   = 3'd0,
        MAP_GEN16K  = 3'd1,
        MAP_KONSCC  = 3'd2,
        MAP_KON4    = 3'd3,
        MAP_ASC8    = 3'd4,
        MAP_ASC16   = 3'd5
    } mapper_t;

    typedef struct packed {
        logic                     row;
        logic                     lane;
        logic [OFS_BITS-1:0]      ofs;
        logic                     hit;
        logic                     wr_en;
        logic                     wr_lo;
        logic                     wr_hi;
        logic [PAGE_MAX_BITS-1:0] lo_val;
        logic [PAGE_MAX_BITS-1:0] hi_val;
        logic                     scc;
        logic                     absorb;
    } acc_t;

endpackage

/* hdl/cartridge_rom_bank_mapper.sv */
// channel | dir | tdata (low bit up)                      | tuser
// s_      | in  | address[15:0], write_data[23:16]        | operation (0 read, 1 write)
// m_      | out | rom_address[20:0], rom_hit[21],         | -
//         |     | scc_enabled[22], scc_write[23]          |
// One beat per cycle unless stalled; a result is registered in s1_reg, then in the queue.
// Page registers live in a two-row RAM, one row per window pair, read at accept and
// written back in the next cycle; the last write is forwarded to the next beat.
// Synchronous active-low reset; page rows read as 0..3 until first written, no clear pass.
// A two-entry output queue absorbs m_tready stalls; s_tready drops only when it would fill.
module cartridge_rom_bank_mapper #(
    parameter int PAGE_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // address[15:0], write_data[23:16]
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // rom_address[20:0], rom_hit, scc_enabled, scc_write
);
    import crbm_pkg::*;

    localparam int ROW_BITS = 2 * PAGE_BITS;

    logic [2:0]          mapper_type_reg;
    logic [7:0]          bank_mask_reg;
    logic                scc_on_reg;
    logic [1:0]          row_valid_reg;
    logic                s1_vld_reg;
    acc_t                s1_reg;
    logic                fwd_vld_reg;
    logic                fwd_row_reg;
    logic [ROW_BITS-1:0] fwd_data_reg;

    acc_t                dec_acc;
    logic                accept;
    logic [1:0]          level;
    logic [2:0]          room;
    logic [ROW_BITS-1:0] ram_rdata;
    logic [ROW_BITS-1:0] cur_row;
    logic [ROW_BITS-1:0] reset_row;
    logic [ROW_BITS-1:0] merged;
    logic [PAGE_BITS-1:0] rd_page;
    logic [ROM_BITS-1:0] rom;
    logic                wr_now;

    assign room     = 3'(level) - 3'(m_tvalid && m_tready) + 3'(s1_vld_reg);
    assign s_tready = (room <= 3'd1);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mapper_type_reg <= MAP_GEN8K;
            bank_mask_reg   <= 8'hFF;
        end else if (cfg_we) begin
            if (cfg_addr == CFG_MAPPER_TYPE) begin
                mapper_type_reg <= cfg_wdata[2:0];
            end else if (cfg_addr == CFG_BANK_MASK) begin
                bank_mask_reg <= cfg_wdata;
            end
        end
    end

    crbm_dec #(
        .PAGE_BITS (PAGE_BITS)
    ) u_dec (
        .op_write    (s_tuser),
        .address     (s_tdata[15:0]),
        .write_data  (s_tdata[23:16]),
        .mapper_type (mapper_type_reg),
        .bank_mask   (bank_mask_reg),
        .scc_on      (scc_on_reg),
        .acc         (dec_acc)
    );

    crbm_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (2)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_now),
        .waddr (s1_reg.row),
        .wdata (merged),
        .re    (accept),
        .raddr (dec_acc.row),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scc_on_reg    <= 1'b0;
            s1_vld_reg    <= 1'b0;
            fwd_vld_reg   <= 1'b0;
            row_valid_reg <= '0;
        end else begin
            s1_vld_reg  <= accept;
            fwd_vld_reg <= wr_now;
            if (accept) begin
                scc_on_reg <= dec_acc.scc;
            end
            if (wr_now) begin
                row_valid_reg[s1_reg.row] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= dec_acc;
        end
        if (wr_now) begin
            fwd_row_reg  <= s1_reg.row;
            fwd_data_reg <= merged;
        end
    end

    assign wr_now    = s1_vld_reg && s1_reg.wr_en;
    assign reset_row = {PAGE_BITS'({s1_reg.row, 1'b1}), PAGE_BITS'({s1_reg.row, 1'b0})};

    always_comb begin
        if (fwd_vld_reg && fwd_row_reg == s1_reg.row) begin
            cur_row = fwd_data_reg;
        end else if (row_valid_reg[s1_reg.row]) begin
            cur_row = ram_rdata;
        end else begin
            cur_row = reset_row;
        end
        merged = cur_row;
        if (s1_reg.wr_lo) begin
            merged[PAGE_BITS-1:0] = s1_reg.lo_val[PAGE_BITS-1:0];
        end
        if (s1_reg.wr_hi) begin
            merged[ROW_BITS-1:PAGE_BITS] = s1_reg.hi_val[PAGE_BITS-1:0];
        end
    end

    assign rd_page = s1_reg.lane ? cur_row[ROW_BITS-1:PAGE_BITS] : cur_row[PAGE_BITS-1:0];
    assign rom     = s1_reg.hit ? ROM_BITS'({rd_page, s1_reg.ofs}) : '0;

    crbm_outq #(
        .WIDTH (24)
    ) u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s1_vld_reg),
        .push_data ({s1_reg.absorb, s1_reg.scc, s1_reg.hit, rom}),
        .level     (level),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

/* hdl/crbm_ram.sv */
module crbm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/crbm_dec.sv */
module crbm_dec #(
    parameter int PAGE_BITS = 8
) (
    input  logic               op_write,
    input  logic [15:0]        address,
    input  logic [7:0]         write_data,
    input  logic [2:0]         mapper_type,
    input  logic [7:0]         bank_mask,
    input  logic               scc_on,
    output crbm_pkg::acc_t     acc
);
    import crbm_pkg::*;

    logic                 in_win;
    logic                 scc_sw;
    logic                 absorb;
    logic                 do_wr;
    logic [7:0]           dbl;
    logic [PAGE_BITS-1:0] pg8;
    logic [PAGE_BITS-1:0] pp;
    logic [PAGE_BITS-1:0] pp1;

    assign in_win = (address[15:14] == 2'b01) || (address[15:14] == 2'b10);
    assign scc_sw = (address == SCC_SWITCH_ADDR) ? (write_data == SCC_KEY) : scc_on;
    assign absorb = op_write && scc_sw && (address[15:8] == SCC_REG_PAGE);
    assign do_wr  = op_write && !absorb;
    assign pg8    = PAGE_BITS'(write_data & bank_mask);
    assign dbl    = {write_data[6:0], 1'b0} & bank_mask;
    assign pp     = dbl[PAGE_BITS-1:0];
    assign pp1    = pp + PAGE_BITS'(1);

    always_comb begin
        acc        = '0;
        acc.row    = address[15];
        acc.lane   = address[13];
        acc.ofs    = address[OFS_BITS-1:0];
        acc.hit    = !op_write && in_win;
        acc.scc    = op_write ? scc_sw : scc_on;
        acc.absorb = absorb;
        if (do_wr) begin
            unique case (mapper_t'(mapper_type))
                MAP_GEN8K: begin
                    if (in_win) begin
                        if (address[15:13] == 3'b100) begin
                            acc.scc = (write_data[5:0] == SCC_KEY[5:0]);
                        end
                        acc.wr_en  = 1'b1;
                        acc.wr_lo  = !address[13];
                        acc.wr_hi  = address[13];
                        acc.lo_val = 8'(pg8);
                        acc.hi_val = 8'(pg8);
                    end
                end
                MAP_GEN16K: begin
                    if (in_win) begin
                        acc.wr_en  = 1'b1;
                        acc.wr_lo  = 1'b1;
                        acc.wr_hi  = 1'b1;
                        acc.lo_val = 8'(pp);
                        acc.hi_val = 8'(pp1);
                    end
                end
                MAP_KONSCC: begin
                    if (address >= 16'h5000 && address <= 16'hB000
                            && address[12:11] == 2'b10) begin
                        if (address[15:11] == 5'b10010) begin
                            acc.scc = (write_data[5:0] == SCC_KEY[5:0]);
                        end
                        acc.wr_en  = 1'b1;
                        acc.wr_lo  = !address[13];
                        acc.wr_hi  = address[13];
                        acc.lo_val = 8'(pg8);
                        acc.hi_val = 8'(pg8);
                    end
                end
                MAP_KON4: begin
                    if ((address == 16'h6000) || (address == 16'h8000)
                            || (address == 16'hA000)) begin
                        acc.wr_en  = 1'b1;
                        acc.wr_lo  = !address[13];
                        acc.wr_hi  = address[13];
                        acc.lo_val = 8'(pg8);
                        acc.hi_val = 8'(pg8);
                    end
                end
                MAP_ASC8: begin
                    if (address[15:13] == 3'b011) begin
                        acc.row    = address[12];
                        acc.wr_en  = 1'b1;
                        acc.wr_lo  = !address[11];
                        acc.wr_hi  = address[11];
                        acc.lo_val = 8'(pg8);
                        acc.hi_val = 8'(pg8);
                    end
                end
                MAP_ASC16: begin
                    if (address[15:13] == 3'b011 && !address[11]) begin
                        acc.row    = address[12];
                        acc.wr_en  = 1'b1;
                        acc.wr_lo  = 1'b1;
                        acc.wr_hi  = 1'b1;
                        acc.lo_val = 8'(pp);
                        acc.hi_val = 8'(pp1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

/* hdl/crbm_outq.sv */
module crbm_outq #(
    parameter int WIDTH = 24
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic [1:0]       level,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [WIDTH-1:0] m_tdata
);

    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    logic [1:0]       cnt_pop;
    logic [WIDTH-1:0] head_reg;
    logic [WIDTH-1:0] skid_reg;
    logic             pop;

    assign pop      = m_tvalid && m_tready;
    assign cnt_pop  = cnt_reg - 2'(pop);
    assign cnt_next = cnt_pop + 2'(push);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && cnt_reg == 2'd2) begin
            head_reg <= skid_reg;
        end
        if (push) begin
            if (cnt_pop == 2'd0) begin
                head_reg <= push_data;
            end else begin
                skid_reg <= push_data;
            end
        end
    end

    assign level    = cnt_reg;
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = head_reg;

endmodule

/* hdl/crbm_chk.sv */
module crbm_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid right after reset");

    a_absorb: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[23] |-> m_tdata[22] && !m_tdata[21])
        else $error("absorbed write without enable flag or with hit");

    a_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[21] |-> m_tdata[20:0] == 21'd0)
        else $error("miss with nonzero rom address");

endmodule

bind cartridge_rom_bank_mapper crbm_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
    import crbm_pkg::*;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;
    localparam int   CYCLE_LIMIT = 200000;
    localparam int   PHASES      = 10;
    localparam int   PHASE_BEATS = 100;
    localparam int   LONG_HOLD   = 60;

    typedef struct packed {
        logic        scc_write;
        logic        scc_enabled;
        logic        rom_hit;
        logic [20:0] rom_address;
    } map_result_t;

    typedef struct {
        mapper_t     mtype;
        logic [7:0]  mask;
        logic        op;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        typed;
        map_result_t res;
    } access_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_addr  = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = 24'h0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;

    cartridge_rom_bank_mapper dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // mapper state as the block should hold it
    logic [7:0]  win_page [4];
    logic        scc_flag;
    mapper_t     map_type;
    logic [7:0]  page_mask_reg;

    map_result_t expected_beats [$];
    access_row_t access_table [26];
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    bit          idle_on = 1'b1;
    bit          stall_on = 1'b1;
    bit          hold_long = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: errors");
        $finish;
    end

    function automatic void load_page(logic [2:0] w, logic [7:0] p);
        if (w >= 3'd2 && w <= 3'd5) win_page[2'(w - 3'd2)] = p;
    endfunction

    function automatic void load_pair(logic [2:0] w, logic [7:0] d);
        logic [7:0] p;
        p = {d[6:0], 1'b0} & page_mask_reg;
        load_page(w, p);
        load_page(w + 3'd1, p + 8'd1);
    endfunction

    function automatic void bank_write(logic [15:0] a, logic [7:0] d);
        logic [15:0] shifted;
        shifted = a - 16'h1000;
        case (map_type)
            MAP_GEN8K: begin
                if (a >= 16'h4000 && a <= 16'hBFFF) begin
                    if (a[15:13] == 3'd4) scc_flag = (d[5:0] == SCC_KEY[5:0]);
                    load_page(a[15:13], d & page_mask_reg);
                end
            end
            MAP_GEN16K: begin
                if (a >= 16'h4000 && a <= 16'hBFFF) load_pair({a[15:14], 1'b0}, d);
            end
            MAP_KONSCC: begin
                if (a >= 16'h5000 && a <= 16'hB000 && a[12:11] == 2'b10) begin
                    if (a[15:11] == 5'b10010) scc_flag = (d[5:0] == SCC_KEY[5:0]);
                    load_page(shifted[15:13], d & page_mask_reg);
                end
            end
            MAP_KON4: begin
                if (a >= 16'h6000 && a <= 16'hA000 && a[12:0] == 13'd0)
                    load_page(a[15:13], d & page_mask_reg);
            end
            MAP_ASC8: begin
                if (a >= 16'h6000 && a <= 16'h7FFF)
                    load_page({1'b0, a[12:11]} + 3'd2, d & page_mask_reg);
            end
            MAP_ASC16: begin
                if (a >= 16'h6000 && a <= 16'h77FF && !a[11])
                    load_pair({1'b0, a[12], 1'b0} + 3'd2, d);
            end
            default: ;
        endcase
    endfunction

    function automatic map_result_t map_access(logic op, logic [15:0] a, logic [7:0] d);
        map_result_t r;
        logic [2:0]  w;
        r = '0;
        w = a[15:13];
        if (op == OP_READ) begin
            if (w >= 3'd2 && w <= 3'd5) begin
                r.rom_address = {win_page[2'(w - 3'd2)], a[12:0]};
                r.rom_hit = 1'b1;
            end
        end else begin
            if (a == SCC_SWITCH_ADDR) scc_flag = (d == SCC_KEY);
            if (scc_flag && a[15:8] == SCC_REG_PAGE) r.scc_write = 1'b1;
            else bank_write(a, d);
        end
        r.scc_enabled = scc_flag;
        return r;
    endfunction

    function automatic logic [15:0] bank_reg_addr(mapper_t t);
        int unsigned k;
        k = $urandom_range(0, 4);
        case (t)
            MAP_GEN8K, MAP_GEN16K: return 16'h4000 + 16'($urandom_range(0, 16'h7FFF));
            MAP_KONSCC: begin
                if (k == 3) return 16'hB000;
                if (k == 4) return 16'h4000 + 16'($urandom_range(0, 16'h7FFF));
                return 16'h5000 + 16'(k * 16'h2000) + 16'($urandom_range(0, 16'h7FF));
            end
            MAP_KON4: begin
                if (k == 4) return 16'h6000 + 16'($urandom_range(0, 16'h5FFF));
                return 16'h6000 + 16'($urandom_range(0, 2) * 16'h2000);
            end
            MAP_ASC8: return 16'h6000 + 16'($urandom_range(0, 16'h1FFF));
            default: return 16'h6000 + 16'($urandom_range(0, 16'h17FF));
        endcase
    endfunction

    task automatic make_access(output logic op, output logic [15:0] a, output logic [7:0] d);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        d = ($urandom_range(0, 7) == 0) ? SCC_KEY : 8'($urandom);
        if (pick < 35) begin
            op = OP_READ;
            a = (pick < 30) ? 16'h4000 + 16'($urandom_range(0, 16'h7FFF)) : 16'($urandom);
        end else if (pick < 80) begin
            op = OP_WRITE;
            a = bank_reg_addr(map_type);
        end else if (pick < 90) begin
            op = OP_WRITE;
            a = ($urandom_range(0, 1) == 0) ? SCC_SWITCH_ADDR
                                            : {SCC_REG_PAGE, 8'($urandom)};
        end else begin
            op = 1'($urandom);
            a = 16'($urandom);
        end
    endtask

    task automatic send_access(logic op, logic [15:0] a, logic [7:0] d,
                               logic typed, map_result_t typed_res);
        map_result_t predicted;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {d, a};
        do @(posedge aclk); while (!s_tready);
        predicted = map_access(op, a, d);
        expected_beats.push_back(typed ? typed_res : predicted);
    endtask

    task automatic finish_phase();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_config(mapper_t t, logic [7:0] m);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_MAPPER_TYPE;
        cfg_wdata <= {5'b0, t};
        @(posedge aclk);
        map_type = t;
        cfg_addr  <= CFG_BANK_MASK;
        cfg_wdata <= m;
        @(posedge aclk);
        page_mask_reg = m;
        cfg_we <= 1'b0;
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_long) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_long = 1'b0;
                m_tready <= 1'b1;
            end else if (stall_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        map_result_t got;
        map_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = map_result_t'(m_tdata);
            if (expected_beats.size() == 0) begin
                $error("result beat %h with nothing expected", m_tdata);
                fail_count++;
            end else begin
                want = expected_beats.pop_front();
                if (got.rom_address !== want.rom_address) begin
                    $error("rom_address: expected %h, got %h", want.rom_address, got.rom_address);
                    fail_count++;
                end
                if (got.rom_hit !== want.rom_hit) begin
                    $error("rom_hit: expected %b, got %b", want.rom_hit, got.rom_hit);
                    fail_count++;
                end
                if (got.scc_enabled !== want.scc_enabled) begin
                    $error("scc_enabled: expected %b, got %b", want.scc_enabled,
                           got.scc_enabled);
                    fail_count++;
                end
                if (got.scc_write !== want.scc_write) begin
                    $error("scc_write: expected %b, got %b", want.scc_write, got.scc_write);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        logic        op;
        logic [15:0] a;
        logic [7:0]  d;
        logic [7:0]  m;
        mapper_t     t;

        win_page      = '{8'd0, 8'd1, 8'd2, 8'd3};
        scc_flag      = 1'b0;
        map_type      = MAP_GEN8K;
        page_mask_reg = 8'hFF;

        access_table = '{
            '{MAP_GEN8K,  8'hFF, OP_READ,  16'h0000, 8'h00, 1'b1, '{1'b0, 1'b0, 1'b0, 21'h0}},
            '{MAP_GEN8K,  8'hFF, OP_READ,  16'h4000, 8'hA5, 1'b1, '{1'b0, 1'b0, 1'b1, 21'h0}},
            '{MAP_GEN8K,  8'hFF, OP_READ,  16'hBFFF, 8'h00, 1'b1,
              '{1'b0, 1'b0, 1'b1, 21'h07FFF}},
            '{MAP_GEN8K,  8'hFF, OP_READ,  16'hFFFF, 8'hFF, 1'b1, '{1'b0, 1'b0, 1'b0, 21'h0}},
            '{MAP_GEN8K,  8'hFF, OP_WRITE, 16'h9000, 8'h3F, 1'b1, '{1'b0, 1'b1, 1'b0, 21'h0}},
            '{MAP_GEN8K,  8'hFF, OP_WRITE, 16'h98FF, 8'hFF, 1'b1, '{1'b1, 1'b1, 1'b0, 21'h0}},
            '{MAP_GEN8K,  8'hFF, OP_READ,  16'h8000, 8'h00, 1'b0, '0},
            '{MAP_GEN8K,  8'hFF, OP_WRITE, 16'h9000, 8'h00, 1'b0, '0},
            '{MAP_GEN8K,  8'hFF, OP_WRITE, 16'h6000, 8'hFF, 1'b0, '0},
            '{MAP_GEN8K,  8'hFF, OP_READ,  16'h7FFF, 8'h00, 1'b1,
              '{1'b0, 1'b0, 1'b1, 21'h1FFFFF}},
            '{MAP_GEN8K,  8'hFF, OP_WRITE, 16'h3FFF, 8'h12, 1'b0, '0},
            '{MAP_GEN16K, 8'h7F, OP_WRITE, 16'h4000, 8'hC1, 1'b0, '0},
            '{MAP_GEN16K, 8'h7F, OP_WRITE, 16'hA000, 8'h7F, 1'b0, '0},
            '{MAP_GEN16K, 8'h7F, OP_READ,  16'hA123, 8'h00, 1'b0, '0},
            '{MAP_KONSCC, 8'hFF, OP_WRITE, 16'h5000, 8'h01, 1'b0, '0},
            '{MAP_KONSCC, 8'hFF, OP_WRITE, 16'hB000, 8'h05, 1'b0, '0},
            '{MAP_KONSCC, 8'hFF, OP_WRITE, 16'hB001, 8'h09, 1'b0, '0},
            '{MAP_KONSCC, 8'hFF, OP_WRITE, 16'h9000, 8'h7F, 1'b0, '0},
            '{MAP_KONSCC, 8'hFF, OP_WRITE, 16'h9800, 8'h44, 1'b0, '0},
            '{MAP_KONSCC, 8'hFF, OP_READ,  16'h9FFF, 8'h00, 1'b0, '0},
            '{MAP_KON4,   8'hFF, OP_WRITE, 16'h6000, 8'h12, 1'b0, '0},
            '{MAP_KON4,   8'hFF, OP_WRITE, 16'h6001, 8'h34, 1'b0, '0},
            '{MAP_KON4,   8'hFF, OP_WRITE, 16'hA000, 8'h56, 1'b0, '0},
            '{MAP_ASC8,   8'h0F, OP_WRITE, 16'h7800, 8'hFF, 1'b0, '0},
            '{MAP_ASC16,  8'h00, OP_WRITE, 16'h7000, 8'h81, 1'b0, '0},
            '{MAP_ASC16,  8'h00, OP_READ,  16'hA000, 8'h00, 1'b0, '0}
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (access_table[i]) begin
            if (access_table[i].mtype != map_type || access_table[i].mask != page_mask_reg) begin
                finish_phase();
                set_config(access_table[i].mtype, access_table[i].mask);
            end
            send_access(access_table[i].op, access_table[i].addr, access_table[i].data,
                        access_table[i].typed, access_table[i].res);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            finish_phase();
            t = (phase < 6) ? mapper_t'(phase) : mapper_t'($urandom_range(0, 5));
            case (phase)
                0: m = 8'hFF;
                1: m = 8'h00;
                2: m = 8'h0F;
                3: m = 8'h7F;
                default: m = 8'($urandom);
            endcase
            set_config(t, m);
            if (phase == 3) hold_long = 1'b1;
            if (phase == PHASES - 1) begin
                idle_on  = 1'b0;
                stall_on = 1'b0;
            end
            repeat (PHASE_BEATS) begin
                make_access(op, a, d);
                send_access(op, a, d, 1'b0, '0);
            end
        end

        finish_phase();
        if (fail_count == 0) $display("tb: clean");
        else $display("tb: errors");
        $finish;
    end

endmodule
